[sv/easing_curve_evaluator_macros.svh]
// Assertion macros for the easing curve evaluator.
`ifndef EASING_CURVE_EVALUATOR_MACROS_SVH
`define EASING_CURVE_EVALUATOR_MACROS_SVH
`define ECE_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ECE_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[sv/ece_pkg.sv]
// Package: constants, sine table and commands of the easing curve evaluator.
package ece_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SINE_ENTRIES_DEF = 256;
  localparam int TIME_BITS_DEF = 16;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [3:0] {
    CMD_LINEAR = 4'd0, CMD_SINE_IN = 4'd1, CMD_SINE_OUT = 4'd2, CMD_SINE_INOUT = 4'd3,
    CMD_CIRC_IN = 4'd4, CMD_CIRC_OUT = 4'd5, CMD_CIRC_INOUT = 4'd6,
    CMD_QUART_IN = 4'd7, CMD_QUART_OUT = 4'd8, CMD_QUART_INOUT = 4'd9
  } cmd_t;

  function automatic logic [30:0] sine_point(input int k, input int entries);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x = (PI_HALF_Q30 * 64'(k)) / 64'(entries);
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > Q30_ONE) sum = Q30_ONE;
    return sum[30:0];
  endfunction
endpackage

[sv/ece_sqrt_stage.sv]
// One pipelined step of the bit-serial square root with its side payload.
module ece_sqrt_stage import ece_pkg::*; #(
  parameter int VW = 48,
  parameter int SIDE = 8,
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [VW-1:0]   in_rem,
  input  logic [VW-1:0]   in_root,
  input  logic [SIDE-1:0] in_side,
  output logic            out_valid,
  output logic [VW-1:0]   out_rem,
  output logic [VW-1:0]   out_root,
  output logic [SIDE-1:0] out_side
);
  localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * STEP);
  logic [VW-1:0] trial;
  logic          take;
  assign trial = in_root + BIT;
  assign take = in_rem >= trial;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rem <= take ? in_rem - trial : in_rem;
      out_root <= take ? (in_root >> 1) + BIT : in_root >> 1;
      out_side <= in_side;
    end
  end
endmodule

[sv/ece_divider.sv]
// Pipelined restoring divider forming p = t * 2^F / d, one quotient bit per stage.
module ece_divider import ece_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SIDE = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SIDE-1:0] in_side,
  output logic            out_valid,
  output logic [NW-1:0]   out_quo,
  output logic [SIDE-1:0] out_side
);
  logic            v   [NW+1];
  logic [NW-1:0]   num [NW+1];
  logic [DW:0]     rem [NW+1];
  logic [DW-1:0]   den [NW+1];
  logic [SIDE-1:0] sd  [NW+1];
  assign v[0] = in_valid;
  assign num[0] = in_num;
  assign rem[0] = '0;
  assign den[0] = in_den;
  assign sd[0] = in_side;
  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW+1:0] sh;
    logic          ge;
    assign sh = {rem[i], num[i][NW-1]};
    assign ge = sh >= {2'b00, den[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        rem[i+1] <= ge ? (DW+1)'(sh - {2'b00, den[i]}) : (DW+1)'(sh);
        num[i+1] <= {num[i][NW-2:0], ge};
        den[i+1] <= den[i];
        sd[i+1] <= sd[i];
      end
    end
  end
  assign out_valid = v[NW];
  assign out_quo = num[NW];
  assign out_side = sd[NW];
endmodule

[sv/easing_curve_evaluator.sv]
// Top level: pipelined easing curve evaluator.
// Usage: present command, elapsed_time, duration, start_value and
// change_amount with in_valid; a request is taken when in_valid and
// in_ready are both high. Results come on eased_value and range_flag with
// out_valid and are taken when out_ready is high.
// Throughput: one request per cycle unless the output stalls. Pipeline:
// TIME_BITS+FRAC_BITS divider stages, three stages for argument selection,
// table read with the first square and interpolation with the second
// square, FRAC_BITS+2 square root stages for the circular curves, and two
// stages for the final scale, add and saturate.
// The pipeline advances as a whole; when the receiver stalls with a
// result waiting, every stage holds, so nothing is lost or repeated, and
// in_ready falls only while the output register is full and not taken.
// Reset clears every valid bit; there is no clearing pass.
module easing_curve_evaluator import ece_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           command,
  input  logic [TIME_BITS-1:0] elapsed_time,
  input  logic [TIME_BITS-1:0] duration,
  input  logic signed [31:0]   start_value,
  input  logic signed [31:0]   change_amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   eased_value,
  output logic                 range_flag
);
  `include "easing_curve_evaluator_macros.svh"
  localparam int F = FRAC_BITS;
  localparam int NW = TIME_BITS + F;
  localparam int SW = 4 + 1 + 1 + 64 + 1;
  localparam int AB = $clog2(SINE_TABLE_ENTRIES);
  localparam int QW = F + 2;
  localparam int RW = 2 * F + 4;
  localparam int RS = RW / 2;
  localparam logic [QW-1:0] ONE = QW'(1) << F;

  typedef struct packed {
    logic [3:0]  cmd;
    logic        zero;
    logic        flag;
    logic [31:0] b;
    logic [31:0] c;
    logic        hi;
  } side_t;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: clamp
  side_t s0_side;
  logic [TIME_BITS-1:0] t_cl;
  logic [TIME_BITS-1:0] d_use;
  always_comb begin
    s0_side.cmd = command;
    s0_side.zero = duration == '0;
    s0_side.flag = (duration == '0) || (elapsed_time > duration);
    s0_side.b = start_value;
    s0_side.c = change_amount;
    s0_side.hi = 1'b0;
    t_cl = (elapsed_time > duration) ? duration : elapsed_time;
    d_use = (duration == '0) ? TIME_BITS'(1) : duration;
  end

  logic          dv;
  logic [NW-1:0] dq;
  side_t         dside;
  ece_divider #(.NW(NW), .DW(TIME_BITS), .SIDE(SW)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid && in_ready),
    .in_num({t_cl, F'(0)}), .in_den(d_use), .in_side(s0_side),
    .out_valid(dv), .out_quo(dq), .out_side(dside));

  // stage A: argument selection
  logic [QW-1:0] p;
  logic [QW:0]   s2;
  logic [QW-1:0] arg;
  logic          sec;
  side_t         aside_next;
  assign p = dside.zero ? ONE : QW'(dq);
  assign s2 = {p, 1'b0};
  always_comb begin
    arg = p;
    sec = 1'b0;
    case (cmd_t'(dside.cmd))
      CMD_SINE_IN: arg = ONE - p;
      CMD_SINE_INOUT: begin
        if (s2 <= {1'b0, ONE}) arg = ONE - QW'(s2);
        else begin arg = QW'(s2 - {1'b0, ONE}); sec = 1'b1; end
      end
      CMD_CIRC_IN: arg = p;
      CMD_CIRC_OUT: arg = ONE - p;
      CMD_CIRC_INOUT, CMD_QUART_INOUT: begin
        if (s2 < {1'b0, ONE}) arg = QW'(s2);
        else begin arg = QW'({ONE, 1'b0} - s2); sec = 1'b1; end
      end
      CMD_QUART_OUT: arg = ONE - p;
      default: arg = p;
    endcase
    aside_next = dside;
    aside_next.hi = sec;
  end

  logic          av;
  logic [QW-1:0] a_arg;
  logic [QW-1:0] a_p;
  side_t         aside;
  always_ff @(posedge clk) begin
    if (rst) av <= 1'b0;
    else if (en) av <= dv;
    if (en) begin
      a_arg <= arg;
      a_p <= p;
      aside <= aside_next;
    end
  end

  // stage B: table read and square
  logic [30:0] lo_v;
  logic [30:0] hi_v;
  logic [QW+AB-1:0] pos;
  logic [AB:0]   idx;
  logic [F-1:0]  frc;
  logic [2*QW-1:0] sq;
  assign pos = (QW+AB)'(a_arg) * (QW+AB)'(SINE_TABLE_ENTRIES);
  assign idx = (AB+1)'(pos >> F);
  assign frc = pos[F-1:0];
  assign sq = a_arg * a_arg;
  always_comb begin
    lo_v = sine_point(SINE_TABLE_ENTRIES, SINE_TABLE_ENTRIES);
    hi_v = lo_v;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      if (idx == (AB+1)'(k)) begin
        lo_v = sine_point(k, SINE_TABLE_ENTRIES);
        hi_v = sine_point(k + 1, SINE_TABLE_ENTRIES);
      end
    end
  end

  logic          bv;
  logic [30:0]   b_lo;
  logic [30:0]   b_diff;
  logic [F-1:0]  b_frc;
  logic [QW-1:0] b_sq;
  logic [QW-1:0] b_p;
  side_t         bside;
  always_ff @(posedge clk) begin
    if (rst) bv <= 1'b0;
    else if (en) bv <= av;
    if (en) begin
      b_lo <= lo_v;
      b_diff <= (hi_v >= lo_v) ? hi_v - lo_v : '0;
      b_frc <= frc;
      b_sq <= QW'(sq >> F);
      b_p <= a_p;
      bside <= aside;
    end
  end

  // stage C: interpolate and second square
  logic [30+F:0]  ip;
  logic [30:0]    iv;
  logic [31:0]    rnd;
  logic [QW-1:0]  sinq;
  logic [2*QW-1:0] sq2;
  assign ip = b_diff * b_frc;
  assign iv = b_lo + 31'(ip >> F);
  assign rnd = ({1'b0, iv} + (32'd1 << (29 - F))) >> (30 - F);
  assign sinq = (rnd > 32'(ONE)) ? ONE : QW'(rnd);
  assign sq2 = b_sq * b_sq;

  logic          cv;
  logic [QW-1:0] c_sin;
  logic [QW-1:0] c_p4;
  logic [QW-1:0] c_sq;
  logic [QW-1:0] c_p;
  side_t         cside;
  always_ff @(posedge clk) begin
    if (rst) cv <= 1'b0;
    else if (en) cv <= bv;
    if (en) begin
      c_sin <= sinq;
      c_p4 <= QW'(sq2 >> F);
      c_sq <= (b_sq > ONE) ? ONE : b_sq;
      c_p <= b_p;
      cside <= bside;
    end
  end

  // square root chain for the circular curves
  localparam int XW = SW + 3 * QW;
  logic          rv   [RS+1];
  logic [RW-1:0] rrem [RS+1];
  logic [RW-1:0] rrt  [RS+1];
  logic [XW-1:0] rx   [RS+1];
  assign rv[0] = cv;
  assign rrem[0] = RW'(ONE - c_sq) << F;
  assign rrt[0] = '0;
  assign rx[0] = {cside, c_sin, c_p4, c_p};
  for (genvar j = 0; j < RS; j++) begin : g_rt
    ece_sqrt_stage #(.VW(RW), .SIDE(XW), .STEP(j)) u_st (
      .clk(clk), .rst(rst), .en(en), .in_valid(rv[j]), .in_rem(rrem[j]),
      .in_root(rrt[j]), .in_side(rx[j]), .out_valid(rv[j+1]),
      .out_rem(rrem[j+1]), .out_root(rrt[j+1]), .out_side(rx[j+1]));
  end

  side_t         eside;
  logic [QW-1:0] e_sin;
  logic [QW-1:0] e_p4;
  logic [QW-1:0] e_p;
  logic [QW-1:0] e_rt;
  logic [QW-1:0] fv;
  assign {eside, e_sin, e_p4, e_p} = rx[RS];
  assign e_rt = QW'(rrt[RS]);
  always_comb begin
    case (cmd_t'(eside.cmd))
      CMD_SINE_IN: fv = ONE - e_sin;
      CMD_SINE_OUT: fv = e_sin;
      CMD_SINE_INOUT: fv = eside.hi ? (ONE + e_sin) >> 1 : (ONE - e_sin) >> 1;
      CMD_CIRC_IN: fv = ONE - e_rt;
      CMD_CIRC_OUT: fv = e_rt;
      CMD_CIRC_INOUT: fv = eside.hi ? (e_rt + ONE) >> 1 : (ONE - e_rt) >> 1;
      CMD_QUART_IN: fv = e_p4;
      CMD_QUART_OUT: fv = ONE - e_p4;
      CMD_QUART_INOUT: fv = eside.hi ? ONE - (e_p4 >> 1) : e_p4 >> 1;
      default: fv = e_p;
    endcase
    if (eside.zero) fv = ONE;
  end

  // stage G: scale
  logic          gv;
  logic signed [32+QW:0] g_prod;
  side_t         gside;
  always_ff @(posedge clk) begin
    if (rst) gv <= 1'b0;
    else if (en) gv <= rv[RS];
    if (en) begin
      g_prod <= $signed(eside.c) * $signed({1'b0, fv});
      gside <= eside;
    end
  end

  // stage H: add and saturate
  logic signed [32+QW:0] scl;
  logic signed [33+QW:0] sum;
  logic signed [33+QW:0] smax;
  logic signed [33+QW:0] smin;
  assign scl = g_prod >>> F;
  assign sum = (34+QW)'($signed(gside.b)) + (34+QW)'(scl);
  assign smax = (34+QW)'(64'sd2147483647);
  assign smin = -(34+QW)'(64'sd2147483648);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= gv;
    if (en) begin
      if (sum > smax) begin
        eased_value <= 32'sh7FFF_FFFF;
        range_flag <= 1'b1;
      end else if (sum < smin) begin
        eased_value <= 32'sh8000_0000;
        range_flag <= 1'b1;
      end else begin
        eased_value <= 32'(sum);
        range_flag <= gside.flag;
      end
    end
  end

  `ECE_ASSERT_IMP(a_ready, clk, rst, out_valid && !out_ready, !in_ready)
  `ECE_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(eased_value))
  `ECE_ASSERT_NXT(a_zero, clk, rst, gv && gside.zero && en, range_flag)
endmodule
